// File: hw/rtl/cnms_pkg.sv
// ----------------------------------------------------------------------------
// cnms_pkg: shared types and calendar helpers for the cron next-match search
// Holds the candidate time record, the step unit opcodes, the register
// indexes and the Gregorian helper functions.
// ----------------------------------------------------------------------------
package cnms_pkg;

    // Default search span in years past the start year
    localparam int YEAR_SPAN_DEF = 5;

    // Candidate year is one bit wider than the field so a carry past 4095 shows
    localparam int YEAR_W      = 12;
    localparam int CAND_YEAR_W = YEAR_W + 1;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 60;

    localparam int MINUTES_PER_HOUR = 60;
    localparam int HOURS_PER_DAY    = 24;
    localparam int DAYS_PER_WEEK    = 7;
    localparam int MONTHS_PER_YEAR  = 12;
    localparam int MAX_MDAY         = 31;
    localparam int LEAP_CYCLE       = 400;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MINUTE_MASK  = 3'd0,
        REG_HOUR_MASK    = 3'd1,
        REG_MDAY_MASK    = 3'd2,
        REG_WEEKDAY_MASK = 3'd3,
        REG_MONTH_MASK   = 3'd4
    } t_reg_idx;

    // Calendar component codes, in search priority order
    typedef enum logic [2:0] {
        COMP_MINUTE  = 3'd0,
        COMP_HOUR    = 3'd1,
        COMP_MDAY    = 3'd2,
        COMP_WEEKDAY = 3'd3,
        COMP_MONTH   = 3'd4
    } t_comp;

    // Step unit operations
    typedef enum logic [2:0] {
        OP_HOLD    = 3'd0,
        OP_REDUCE  = 3'd1,
        OP_CLAMP   = 3'd2,
        OP_CLEAR   = 3'd3,
        OP_ADVANCE = 3'd4
    } t_op;

    // Candidate time; ym400 is the year modulo 400 once reduced
    typedef struct packed {
        logic [CAND_YEAR_W-1:0] year;
        logic [YEAR_W-1:0]      ym400;
        logic [3:0]             month;
        logic [4:0]             mday;
        logic [4:0]             hour;
        logic [5:0]             minute;
        logic [2:0]             weekday;
    } t_cand;

    // Allowed-value masks
    typedef struct packed {
        logic [MINUTES_PER_HOUR-1:0] minute;
        logic [HOURS_PER_DAY-1:0]    hour;
        logic [MAX_MDAY-1:0]         mday;
        logic [DAYS_PER_WEEK-1:0]    weekday;
        logic [MONTHS_PER_YEAR-1:0]  month;
    } t_masks;

    // Search result handed to the output register
    typedef struct packed {
        logic              found;
        logic [YEAR_W-1:0] year;
        logic [3:0]        month;
        logic [4:0]        mday;
        logic [4:0]        hour;
        logic [5:0]        minute;
        logic [2:0]        weekday;
    } t_result;

    // Gregorian leap test on a year already reduced modulo 400
    function automatic logic is_leap(input logic [YEAR_W-1:0] ym400);
        return (ym400[1:0] == 2'd0) && (ym400 != YEAR_W'(100)) &&
               (ym400 != YEAR_W'(200)) && (ym400 != YEAR_W'(300));
    endfunction

    // Length of a month, 1 to 12
    function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
        logic [4:0] d;
        case (month)
            4'd2:                      d = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
            default:                   d = 5'd31;
        endcase
        return d;
    endfunction

    // Remainder by seven of a 5-bit value by conditional subtraction
    function automatic logic [2:0] mod7_5b(input logic [4:0] x);
        logic [4:0] v;
        v = x;
        if (v >= 5'd28) v = v - 5'd28;
        if (v >= 5'd14) v = v - 5'd14;
        if (v >= 5'd7)  v = v - 5'd7;
        return v[2:0];
    endfunction

    // Weekday plus an offset 0..7, modulo seven
    function automatic logic [2:0] wd_add(input logic [2:0] wd, input logic [2:0] k);
        logic [3:0] s;
        s = {1'b0, wd} + {1'b0, k};
        if (s >= 4'd7) s = s - 4'd7;
        return s[2:0];
    endfunction

endpackage

// File: hw/rtl/cron_next_match_search.sv
// ----------------------------------------------------------------------------
// cron_next_match_search: next matching minute of a cron schedule
// Usage: load the five allowed-value masks through the configuration
// channel (i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data; always ready,
// unknown indexes ignored). Present a start time on the input channel
// (i_valid/o_ready); the block finds the first minute strictly after it
// whose minute, hour, day of month, weekday and month all match, or
// reports o_found = 0 with all fields zero when nothing matches within
// YEAR_SPAN years of the start year.
// After the accept the year is reduced modulo 400, the day is clamped and
// the candidate moves to the first minute after the start; then each check
// pass clears below the first failing component and advances it until it
// matches, and the next pass follows, until a full match or give-up.
// The one step unit moves the candidate a minute, hour, day or month a cycle.
// o_ready is high only while the sequencer is idle; one item is in work at
// a time. The result sits in an output register; while the receiver stalls
// (i_ready low) the next item may be accepted and searched, and it waits
// for the register to drain.
// Reset clears the masks to zero, empties the output register and returns
// the sequencer to idle.
// ----------------------------------------------------------------------------
module cron_next_match_search #(
    parameter int YEAR_SPAN = cnms_pkg::YEAR_SPAN_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [cnms_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cnms_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [11:0]                    i_start_year,
    input  logic [3:0]                     i_start_month,
    input  logic [4:0]                     i_start_mday,
    input  logic [4:0]                     i_start_hour,
    input  logic [5:0]                     i_start_minute,
    input  logic [2:0]                     i_start_weekday,
    // output channel
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_found,
    output logic [11:0]                    o_next_year,
    output logic [3:0]                     o_next_month,
    output logic [4:0]                     o_next_mday,
    output logic [4:0]                     o_next_hour,
    output logic [5:0]                     o_next_minute,
    output logic [2:0]                     o_next_weekday
);

    cnms_pkg::t_masks  r_masks;
    logic              r_out_valid;
    cnms_pkg::t_result r_out;

    logic              seq_idle;
    logic              res_valid;
    logic              res_take;
    cnms_pkg::t_result res;

    // Write the addressed mask; unknown indexes drop the beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_masks <= '0;
        end else if (i_cfg_valid) begin
            case (cnms_pkg::t_reg_idx'(i_cfg_index))
                cnms_pkg::REG_MINUTE_MASK:  r_masks.minute  <= i_cfg_data;
                cnms_pkg::REG_HOUR_MASK:    r_masks.hour    <= i_cfg_data[23:0];
                cnms_pkg::REG_MDAY_MASK:    r_masks.mday    <= i_cfg_data[30:0];
                cnms_pkg::REG_WEEKDAY_MASK: r_masks.weekday <= i_cfg_data[6:0];
                cnms_pkg::REG_MONTH_MASK:   r_masks.month   <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    cnms_seq #(
        .YEAR_SPAN (YEAR_SPAN)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (i_valid && seq_idle),
        .i_year      (i_start_year),
        .i_month     (i_start_month),
        .i_mday      (i_start_mday),
        .i_hour      (i_start_hour),
        .i_minute    (i_start_minute),
        .i_weekday   (i_start_weekday),
        .i_masks     (r_masks),
        .i_res_take  (res_take),
        .o_idle      (seq_idle),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    assign o_ready  = seq_idle;
    assign res_take = res_valid && (!r_out_valid || i_ready);

    // Output register: fill from the sequencer, drain on the output beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_found        = r_out.found;
    assign o_next_year    = r_out.year;
    assign o_next_month   = r_out.month;
    assign o_next_mday    = r_out.mday;
    assign o_next_hour    = r_out.hour;
    assign o_next_minute  = r_out.minute;
    assign o_next_weekday = r_out.weekday;

endmodule

// File: hw/rtl/cnms_step_unit.sv
// ----------------------------------------------------------------------------
// cnms_step_unit: shared calendar step unit
// Applies one operation per cycle to the candidate time: year reduction
// modulo 400, day clamping, clearing of lower components, or one advance of
// a component with full Gregorian carries.
// ----------------------------------------------------------------------------
module cnms_step_unit (
    input  cnms_pkg::t_cand i_cand,
    input  cnms_pkg::t_op   i_op,
    input  cnms_pkg::t_comp i_comp,
    output cnms_pkg::t_cand o_cand
);

    cnms_pkg::t_cand c;
    logic [4:0]      dim;
    logic            inc_hour;
    logic            inc_day;
    logic            inc_month;
    logic            inc_year;

    always_comb begin
        c         = i_cand;
        dim       = cnms_pkg::days_in(i_cand.month, cnms_pkg::is_leap(i_cand.ym400));
        inc_hour  = 1'b0;
        inc_day   = 1'b0;
        inc_month = 1'b0;
        inc_year  = 1'b0;

        case (i_op)
            // Subtract one leap cycle if the remainder is 400 or more
            cnms_pkg::OP_REDUCE: begin
                if (c.ym400 >= cnms_pkg::YEAR_W'(cnms_pkg::LEAP_CYCLE)) begin
                    c.ym400 = c.ym400 - cnms_pkg::YEAR_W'(cnms_pkg::LEAP_CYCLE);
                end
            end

            // Pull the day of month into the month's range
            cnms_pkg::OP_CLAMP: begin
                if (c.mday == 5'd0) begin
                    c.mday = 5'd1;
                end else if (c.mday > dim) begin
                    c.mday = dim;
                end
            end

            // Reset the components below the one that failed
            cnms_pkg::OP_CLEAR: begin
                if (i_comp == cnms_pkg::COMP_MONTH) begin
                    c.weekday = cnms_pkg::wd_add(c.weekday,
                        3'd7 - cnms_pkg::mod7_5b(c.mday - 5'd1));
                    c.mday    = 5'd1;
                end
                if (i_comp inside {cnms_pkg::COMP_MDAY, cnms_pkg::COMP_WEEKDAY,
                                   cnms_pkg::COMP_MONTH}) begin
                    c.hour = 5'd0;
                end
                if (i_comp != cnms_pkg::COMP_MINUTE) begin
                    c.minute = 6'd0;
                end
            end

            // Advance one component and ripple the carries upward
            cnms_pkg::OP_ADVANCE: begin
                case (i_comp)
                    cnms_pkg::COMP_MINUTE: begin
                        if (c.minute == 6'(cnms_pkg::MINUTES_PER_HOUR - 1)) begin
                            c.minute = 6'd0;
                            inc_hour = 1'b1;
                        end else begin
                            c.minute = c.minute + 6'd1;
                        end
                    end
                    cnms_pkg::COMP_HOUR:    inc_hour = 1'b1;
                    cnms_pkg::COMP_MDAY,
                    cnms_pkg::COMP_WEEKDAY: inc_day  = 1'b1;
                    default: begin
                        // Day is 1 here, so the weekday moves by the month length
                        c.weekday = cnms_pkg::wd_add(c.weekday, 3'(dim - 5'd28));
                        inc_month = 1'b1;
                    end
                endcase

                if (inc_hour) begin
                    if (c.hour == 5'(cnms_pkg::HOURS_PER_DAY - 1)) begin
                        c.hour  = 5'd0;
                        inc_day = 1'b1;
                    end else begin
                        c.hour = c.hour + 5'd1;
                    end
                end

                if (inc_day) begin
                    c.weekday = cnms_pkg::wd_add(c.weekday, 3'd1);
                    if (c.mday >= dim) begin
                        c.mday    = 5'd1;
                        inc_month = 1'b1;
                    end else begin
                        c.mday = c.mday + 5'd1;
                    end
                end

                if (inc_month) begin
                    if (c.month == 4'(cnms_pkg::MONTHS_PER_YEAR)) begin
                        c.month  = 4'd1;
                        inc_year = 1'b1;
                    end else begin
                        c.month = c.month + 4'd1;
                    end
                end

                if (inc_year) begin
                    c.year = c.year + cnms_pkg::CAND_YEAR_W'(1);
                    if (c.ym400 == cnms_pkg::YEAR_W'(cnms_pkg::LEAP_CYCLE - 1)) begin
                        c.ym400 = '0;
                    end else begin
                        c.ym400 = c.ym400 + cnms_pkg::YEAR_W'(1);
                    end
                end
            end

            default: ;
        endcase
    end

    assign o_cand = c;

endmodule

// File: hw/rtl/cnms_seq.sv
// ----------------------------------------------------------------------------
// cnms_seq: search sequencer
// Loads and normalizes the start time, then drives the shared step unit
// through the component checks and advances until a match or give-up.
// ----------------------------------------------------------------------------
module cnms_seq #(
    parameter int YEAR_SPAN = cnms_pkg::YEAR_SPAN_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic [11:0]       i_year,
    input  logic [3:0]        i_month,
    input  logic [4:0]        i_mday,
    input  logic [4:0]        i_hour,
    input  logic [5:0]        i_minute,
    input  logic [2:0]        i_weekday,
    input  cnms_pkg::t_masks  i_masks,
    input  logic              i_res_take,
    output logic              o_idle,
    output logic              o_res_valid,
    output cnms_pkg::t_result o_res
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_REDUCE = 7'b0000010,
        S_CLAMP  = 7'b0000100,
        S_BUMP   = 7'b0001000,
        S_CHECK  = 7'b0010000,
        S_ADV    = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

    t_state                      r_state, n_state;
    cnms_pkg::t_cand             r_cand, n_cand;
    logic [cnms_pkg::YEAR_W-1:0] r_origin;
    cnms_pkg::t_comp             r_comp, n_comp;
    logic                        r_first, n_first;
    logic                        r_found, n_found;

    cnms_pkg::t_op               step_op;
    cnms_pkg::t_comp             step_comp;
    cnms_pkg::t_cand             step_out;
    cnms_pkg::t_cand             load_cand;
    logic [4:0]                  ok;
    logic                        over;
    logic                        ok_sel;
    cnms_pkg::t_comp             fail_comp;

    cnms_step_unit u_step (
        .i_cand (r_cand),
        .i_op   (step_op),
        .i_comp (step_comp),
        .o_cand (step_out)
    );

    // Normalize the raw start fields; day clamping waits for the leap test
    always_comb begin
        load_cand.year  = {1'b0, i_year};
        load_cand.ym400 = i_year;
        load_cand.month = (i_month == 4'd0) ? 4'd1 :
                          (i_month > 4'd12) ? 4'd12 : i_month;
        load_cand.mday  = i_mday;
        load_cand.hour  = (i_hour > 5'd23) ? 5'd23 : i_hour;
        load_cand.minute = (i_minute > 6'd59) ? 6'd59 : i_minute;
        load_cand.weekday = (i_weekday == 3'd7) ? 3'd0 : i_weekday;
    end

    // Component match flags on the current candidate
    always_comb begin
        ok[0] = (r_cand.minute < 6'd60) && i_masks.minute[r_cand.minute];
        ok[1] = (r_cand.hour < 5'd24) && i_masks.hour[r_cand.hour];
        ok[2] = (r_cand.mday != 5'd0) && i_masks.mday[r_cand.mday - 5'd1];
        ok[3] = (r_cand.weekday != 3'd7) && i_masks.weekday[r_cand.weekday];
        ok[4] = (r_cand.month != 4'd0) && (r_cand.month <= 4'd12) &&
                i_masks.month[r_cand.month - 4'd1];
    end

    // Pick the first failing component, lowest first
    always_comb begin
        if (!ok[0]) begin
            fail_comp = cnms_pkg::COMP_MINUTE;
        end else if (!ok[1]) begin
            fail_comp = cnms_pkg::COMP_HOUR;
        end else if (!ok[2]) begin
            fail_comp = cnms_pkg::COMP_MDAY;
        end else if (!ok[3]) begin
            fail_comp = cnms_pkg::COMP_WEEKDAY;
        end else begin
            fail_comp = cnms_pkg::COMP_MONTH;
        end
    end

    assign ok_sel = ok[r_comp];
    assign over   = (r_cand.year - {1'b0, r_origin}) >
                    cnms_pkg::CAND_YEAR_W'(YEAR_SPAN);

    // Sequencer next state and step unit control
    always_comb begin
        n_state   = r_state;
        n_comp    = r_comp;
        n_first   = r_first;
        n_found   = r_found;
        step_op   = cnms_pkg::OP_HOLD;
        step_comp = r_comp;

        case (r_state)
            S_IDLE: begin
                if (i_load) begin
                    n_state = S_REDUCE;
                end
            end
            S_REDUCE: begin
                step_op = cnms_pkg::OP_REDUCE;
                if (r_cand.ym400 < cnms_pkg::YEAR_W'(2 * cnms_pkg::LEAP_CYCLE)) begin
                    n_state = S_CLAMP;
                end
            end
            S_CLAMP: begin
                step_op = cnms_pkg::OP_CLAMP;
                n_state = S_BUMP;
            end
            S_BUMP: begin
                step_op   = cnms_pkg::OP_ADVANCE;
                step_comp = cnms_pkg::COMP_MINUTE;
                n_state   = S_CHECK;
            end
            S_CHECK: begin
                if (&ok) begin
                    n_found = ~r_cand.year[cnms_pkg::CAND_YEAR_W-1];
                    n_state = S_DONE;
                end else begin
                    step_op   = cnms_pkg::OP_CLEAR;
                    step_comp = fail_comp;
                    n_comp    = fail_comp;
                    n_first   = 1'b1;
                    n_state   = S_ADV;
                end
            end
            S_ADV: begin
                if (!r_first && over) begin
                    n_found = 1'b0;
                    n_state = S_DONE;
                end else if (!r_first && ok_sel) begin
                    n_state = S_CHECK;
                end else begin
                    step_op = cnms_pkg::OP_ADVANCE;
                    n_first = 1'b0;
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Candidate register: load at accept, else take the step unit result
    always_comb begin
        if (r_state == S_IDLE) begin
            n_cand = i_load ? load_cand : r_cand;
        end else begin
            n_cand = step_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_comp  <= cnms_pkg::COMP_MINUTE;
            r_first <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_comp  <= n_comp;
            r_first <= n_first;
            r_found <= n_found;
        end
    end

    // Candidate and origin carry no reset
    always_ff @(posedge i_clk) begin
        r_cand <= n_cand;
        if (r_state == S_IDLE && i_load) begin
            r_origin <= i_year;
        end
    end

    // Result view; fields read as zero when nothing was found
    always_comb begin
        o_res.found   = r_found;
        o_res.year    = r_found ? r_cand.year[cnms_pkg::YEAR_W-1:0] : '0;
        o_res.month   = r_found ? r_cand.month   : '0;
        o_res.mday    = r_found ? r_cand.mday    : '0;
        o_res.hour    = r_found ? r_cand.hour    : '0;
        o_res.minute  = r_found ? r_cand.minute  : '0;
        o_res.weekday = r_found ? r_cand.weekday : '0;
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);

endmodule

// File: hw/rtl/cnms_checker.sv
// ----------------------------------------------------------------------------
// cnms_checker: port-level checks for the cron next-match search
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module cnms_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_found,
    input logic [11:0] o_next_year,
    input logic [3:0]  o_next_month,
    input logic [4:0]  o_next_mday,
    input logic [4:0]  o_next_hour,
    input logic [5:0]  o_next_minute,
    input logic [2:0]  o_next_weekday
);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_found) &&
        $stable(o_next_year) && $stable(o_next_minute) && $stable(o_next_mday))
        else $error("stalled result changed");

    // A miss reports all fields as zero
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> o_next_year == 12'd0 && o_next_month == 4'd0 &&
        o_next_mday == 5'd0 && o_next_hour == 5'd0 && o_next_minute == 6'd0 &&
        o_next_weekday == 3'd0)
        else $error("miss result carries nonzero fields");

    // A hit reports a well-formed calendar time
    a_hit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_found |-> o_next_month != 4'd0 && o_next_month <= 4'd12 &&
        o_next_mday != 5'd0 && o_next_hour < 5'd24 && o_next_minute < 6'd60 &&
        o_next_weekday < 3'd7)
        else $error("found result out of calendar range");

    // Drop ready for the search after an accepted input beat
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready stayed high after accept");

    // Come out of reset with an empty output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind cron_next_match_search cnms_checker u_cnms_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_found        (o_found),
    .o_next_year    (o_next_year),
    .o_next_month   (o_next_month),
    .o_next_mday    (o_next_mday),
    .o_next_hour    (o_next_hour),
    .o_next_minute  (o_next_minute),
    .o_next_weekday (o_next_weekday)
);
